FILE: src/oil_pkg.sv
package oil_pkg;

  localparam int unsigned LIST_DEPTH = 16;
  localparam int unsigned IDX_W      = $clog2(LIST_DEPTH);
  localparam int unsigned CNT_W      = $clog2(LIST_DEPTH + 1);
  localparam int unsigned POS_W      = 4;
  localparam int unsigned CMP_W      = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned VAL_W      = 32;
  localparam int unsigned RES_CNT_W  = 5;

  localparam int unsigned IN_DATA_W  = 40;
  localparam int unsigned OUT_DATA_W = 8;

  localparam logic STATUS_DONE = 1'b0;
  localparam logic STATUS_FULL = 1'b1;

  typedef enum logic [1:0] {
    OP_APPEND     = 2'd0,
    OP_REMOVE_ALL = 2'd1,
    OP_REMOVE_AT  = 2'd2
  } oil_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } oil_state_e;

  typedef struct packed {
    logic [1:0]              op;
    logic signed [VAL_W-1:0] value;
    logic [POS_W-1:0]        position;
  } oil_req_t;

  typedef struct packed {
    logic                 status;
    logic [RES_CNT_W-1:0] count;
  } oil_res_t;

endpackage

FILE: src/oil_engine.sv
module oil_engine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              req_valid_i,
  output logic              req_ready_o,
  input  oil_pkg::oil_req_t req_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output oil_pkg::oil_res_t res_o
);

  localparam int unsigned CNT_W = oil_pkg::CNT_W;
  localparam int unsigned IDX_W = oil_pkg::IDX_W;
  localparam int unsigned CMP_W = oil_pkg::CMP_W;
  localparam int unsigned VAL_W = oil_pkg::VAL_W;

  oil_pkg::oil_state_e state_q, state_d;

  logic [1:0]       op_q, op_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [CNT_W-1:0] rd_q, rd_d;
  logic [CNT_W-1:0] wr_q, wr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             pend_q, pend_d;
  logic             status_q, status_d;

  logic [VAL_W-1:0] mem [oil_pkg::LIST_DEPTH];
  logic [VAL_W-1:0] rdata_q;
  logic             we, re;
  logic [IDX_W-1:0] waddr, raddr;
  logic [VAL_W-1:0] wdata;

  logic             start;
  logic             full;
  logic             pos_out;
  logic             more_reads;
  logic             keep;
  logic [CMP_W:0]   pos_next;
  logic [31:0]      cnt_ext;

  assign start      = req_valid_i && (state_q == oil_pkg::ST_IDLE);
  assign full       = (count_q == CNT_W'(oil_pkg::LIST_DEPTH));
  assign pos_out    = (CMP_W'(req_i.position) >= CMP_W'(count_q));
  assign pos_next   = (CMP_W + 1)'(req_i.position) + (CMP_W + 1)'(1);
  assign more_reads = (rd_q < count_q);
  assign keep       = (op_q == oil_pkg::OP_REMOVE_AT) || (rdata_q != val_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      oil_pkg::ST_IDLE: begin
        if (req_valid_i) begin
          if ((req_i.op == oil_pkg::OP_REMOVE_ALL) ||
              ((req_i.op == oil_pkg::OP_REMOVE_AT) && !pos_out)) begin
            state_d = oil_pkg::ST_WALK;
          end else begin
            state_d = oil_pkg::ST_DONE;
          end
        end
      end
      oil_pkg::ST_WALK: begin
        if (!pend_q && !more_reads) begin
          state_d = oil_pkg::ST_DONE;
        end
      end
      oil_pkg::ST_DONE: begin
        if (res_ready_i) begin
          state_d = oil_pkg::ST_IDLE;
        end
      end
      default: state_d = oil_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_d     = op_q;
    val_d    = val_q;
    rd_d     = rd_q;
    wr_d     = wr_q;
    count_d  = count_q;
    pend_d   = 1'b0;
    status_d = status_q;
    we       = 1'b0;
    waddr    = wr_q[IDX_W-1:0];
    wdata    = rdata_q;
    re       = 1'b0;
    raddr    = rd_q[IDX_W-1:0];
    unique case (state_q)
      oil_pkg::ST_IDLE: begin
        if (start) begin
          op_d     = req_i.op;
          val_d    = req_i.value;
          status_d = oil_pkg::STATUS_DONE;
          unique case (req_i.op)
            oil_pkg::OP_APPEND: begin
              if (full) begin
                status_d = oil_pkg::STATUS_FULL;
              end else begin
                we      = 1'b1;
                waddr   = count_q[IDX_W-1:0];
                wdata   = req_i.value;
                count_d = count_q + CNT_W'(1);
              end
            end
            oil_pkg::OP_REMOVE_ALL: begin
              rd_d = '0;
              wr_d = '0;
            end
            oil_pkg::OP_REMOVE_AT: begin
              rd_d = CNT_W'(pos_next);
              wr_d = CNT_W'(req_i.position);
            end
            default: ;
          endcase
        end
      end
      oil_pkg::ST_WALK: begin
        if (more_reads) begin
          re     = 1'b1;
          rd_d   = rd_q + CNT_W'(1);
          pend_d = 1'b1;
        end
        if (pend_q && keep) begin
          we   = 1'b1;
          wr_d = wr_q + CNT_W'(1);
        end
        if (!pend_q && !more_reads) begin
          count_d = wr_q;
        end
      end
      oil_pkg::ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= oil_pkg::ST_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      status_q <= oil_pkg::STATUS_DONE;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      pend_q   <= pend_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q  <= op_d;
    val_q <= val_d;
    rd_q  <= rd_d;
    wr_q  <= wr_d;
  end

  // read runs ahead of write, so the same entry is never hit in one cycle
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  assign cnt_ext      = 32'(count_q);
  assign req_ready_o  = (state_q == oil_pkg::ST_IDLE);
  assign res_valid_o  = (state_q == oil_pkg::ST_DONE);
  assign res_o.status = status_q;
  assign res_o.count  = cnt_ext[oil_pkg::RES_CNT_W-1:0];

endmodule

FILE: src/ordered_int_list.sv
// Bounded ordered list of signed 32-bit integers, one operation per transaction.
// Slave side: op (append, remove all equal to value, remove at position),
// value and position. Master side: one result per operation, a status
// (done, or append refused because full) and the count after the operation.
// Entries sit in a single-port-write, registered-read memory of LIST_DEPTH words.
// Append, a refused or ignored operation and a position past the count go from
// idle straight to the done state; the result then passes the output register.
// Remove-all and remove-at walk the held entries from the start or from the one
// after the position, one memory read and at most one write-back per cycle; at
// the end of the walk the engine moves to the done state and the result passes
// the output register. One operation is in flight at a time; the next is taken
// the cycle after the previous result has moved into the output register.
// Reset empties the list at once; no clearing pass is needed.
// A stalled master side holds the result in the output register; a second
// finished result waits in the engine, and the slave side then stalls.
module ordered_int_list (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // op [1:0], value [33:2], position [37:34], zero [39:38]
  input  logic [oil_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // status [0], count [5:1], zero [7:6]
  output logic [oil_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  oil_pkg::oil_req_t req;
  oil_pkg::oil_res_t res;
  oil_pkg::oil_res_t out_q;
  logic              res_valid;
  logic              res_take;
  logic              out_valid_q;

  assign req.op       = s_axis_tdata_i[1:0];
  assign req.value    = s_axis_tdata_i[33:2];
  assign req.position = s_axis_tdata_i[37:34];

  assign res_take = res_valid && (!out_valid_q || m_axis_tready_i);

  oil_engine u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (s_axis_tvalid_i),
    .req_ready_o (s_axis_tready_o),
    .req_i       (req),
    .res_valid_o (res_valid),
    .res_ready_i (res_take),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_q.count, out_q.status};

endmodule

FILE: tb/tb_ordered_int_list.sv
module tb_ordered_int_list;
  import oil_pkg::*;

  localparam logic [1:0]  OP_UNUSED   = 2'd3;
  localparam int unsigned N_RANDOM    = 1280;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned HOLD_AFTER  = 300;

  class list_mirror;
    logic [VAL_W-1:0] held [LIST_DEPTH];
    int unsigned      held_n;
    oil_res_t         due [$];
    int unsigned      n_bad;

    function new();
      held_n = 0;
      n_bad  = 0;
    endfunction

    function void apply_op(logic [1:0] op, logic [VAL_W-1:0] value, logic [POS_W-1:0] pos);
      oil_res_t    res;
      int unsigned wr;
      res.status = STATUS_DONE;
      case (op)
        OP_APPEND: begin
          if (held_n >= LIST_DEPTH) begin
            res.status = STATUS_FULL;
          end else begin
            held[held_n] = value;
            held_n++;
          end
        end
        OP_REMOVE_ALL: begin
          wr = 0;
          for (int unsigned rd = 0; rd < held_n; rd++) begin
            if (held[rd] !== value) begin
              held[wr] = held[rd];
              wr++;
            end
          end
          held_n = wr;
        end
        OP_REMOVE_AT: begin
          if (pos < held_n) begin
            for (int unsigned i = pos; i + 1 < held_n; i++) held[i] = held[i+1];
            held_n--;
          end
        end
        default: begin
        end
      endcase
      res.count = held_n[RES_CNT_W-1:0];
      due.push_back(res);
    endfunction

    function void match_result(logic [OUT_DATA_W-1:0] data);
      oil_res_t want;
      if (due.size() == 0) begin
        if (n_bad < 10)
          $display("unexpected result: status %0d count %0d", data[0], data[RES_CNT_W:1]);
        n_bad++;
        return;
      end
      want = due.pop_front();
      if (data[0] !== want.status || data[RES_CNT_W:1] !== want.count) begin
        if (n_bad < 10)
          $display("result mismatch: status exp %0d got %0d, count exp %0d got %0d",
                   want.status, data[0], want.count, data[RES_CNT_W:1]);
        n_bad++;
      end
    endfunction
  endclass

  logic                  clk_i;
  logic                  rst_ni;
  logic                  s_tvalid;
  logic [IN_DATA_W-1:0]  s_tdata;
  logic                  s_tready;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [OUT_DATA_W-1:0] m_tdata;

  list_mirror       mirror;
  int unsigned      n_taken = 0;
  logic [VAL_W-1:0] pool [8];

  ordered_int_list u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // transaction monitor on both sides
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if (s_tvalid && s_tready) begin
        mirror.apply_op(s_tdata[1:0], s_tdata[VAL_W+1:2], s_tdata[VAL_W+POS_W+1:VAL_W+2]);
        n_taken++;
      end
      if (m_tvalid && m_tready) mirror.match_result(m_tdata);
    end
  end

  // receiver: shifting ready ratio, one long hold-off to back the block up
  initial begin
    int unsigned hold_left;
    int unsigned pct;
    int unsigned tick;
    bit          held_off;
    m_tready  <= 1'b0;
    hold_left = 0;
    pct       = 100;
    tick      = 0;
    held_off  = 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (hold_left != 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (!held_off && n_taken >= HOLD_AFTER) begin
        held_off  = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        m_tready <= 1'b0;
      end else begin
        if (tick % 64 == 0) begin
          case ($urandom_range(0, 3))
            0:       pct = 100;
            1:       pct = 80;
            2:       pct = 50;
            default: pct = 15;
          endcase
        end
        tick++;
        m_tready <= ($urandom_range(1, 100) <= pct);
      end
    end
  end

  task automatic send_op(logic [1:0] op, logic [VAL_W-1:0] value, logic [POS_W-1:0] pos);
    s_tdata  <= {{(IN_DATA_W-VAL_W-POS_W-2){1'b0}}, pos, value, op};
    s_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic wait_empty();
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (mirror.due.size() != 0);
  endtask

  function automatic logic [1:0] pick_op(bit grow);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 5) return OP_UNUSED;
    if (grow) begin
      if (r < 70) return OP_APPEND;
      if (r < 78) return OP_REMOVE_ALL;
      return OP_REMOVE_AT;
    end
    if (r < 30) return OP_APPEND;
    if (r < 60) return OP_REMOVE_ALL;
    return OP_REMOVE_AT;
  endfunction

  function automatic logic [VAL_W-1:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) return $urandom();
    if (r < 45 && mirror.held_n != 0) return mirror.held[$urandom_range(0, mirror.held_n - 1)];
    return pool[$urandom_range(0, 7)];
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    if (mirror.held_n != 0 && $urandom_range(0, 99) < 65)
      return POS_W'($urandom_range(0, mirror.held_n - 1));
    return POS_W'($urandom_range(0, (1 << POS_W) - 1));
  endfunction

  initial begin
    bit          grow;
    int unsigned burst_left;
    int unsigned gap;
    mirror = new();
    rst_ni   <= 1'b0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    pool[0] = 32'h7FFF_FFFF;
    pool[1] = 32'h8000_0000;
    pool[2] = 32'h0000_0000;
    pool[3] = 32'hFFFF_FFFF;
    for (int k = 4; k < 8; k++) pool[k] = $urandom();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty list: position past count, no match, unused op
    send_op(OP_REMOVE_AT, '0, '0);
    send_op(OP_REMOVE_ALL, '0, '0);
    send_op(OP_UNUSED, 32'hFFFF_FFFF, 4'hF);
    // only entry removed
    send_op(OP_APPEND, 32'h8000_0000, '0);
    send_op(OP_REMOVE_AT, '0, '0);
    // fill to the brim with the extreme values, then append on full
    for (int k = 0; k < LIST_DEPTH; k++) send_op(OP_APPEND, pool[k % 4], POS_W'(k));
    send_op(OP_APPEND, 32'h1234_5678, '0);
    send_op(OP_REMOVE_AT, '0, 4'hF);
    send_op(OP_REMOVE_ALL, 32'hFFFF_FFFF, '0);
    send_op(OP_REMOVE_ALL, 32'h0000_0001, '0);
    send_op(OP_REMOVE_AT, '0, 4'hF);
    send_op(OP_REMOVE_AT, '0, '0);
    wait_empty();

    burst_left = $urandom_range(1, 24);
    for (int i = 0; i < N_RANDOM; i++) begin
      grow = ((i / 40) % 2 == 0);
      if (i == N_RANDOM / 2) wait_empty();
      send_op(pick_op(grow), pick_value(), pick_pos());
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        if (gap != 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
      end
    end

    wait_empty();
    repeat (50) @(posedge clk_i);
    if (mirror.n_bad == 0 && mirror.due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
